>>> rtl/core/slbm_pkg.sv
// Shared types and constants for the serial-loaded bank mapper.
// Used by slbm_map and serial_loaded_bank_mapper; depends on nothing.
package slbm_pkg;

  localparam int unsigned CmdW     = 3;
  localparam int unsigned AddrW    = 16;
  localparam int unsigned DataW    = 8;
  localparam int unsigned TgtW     = 3;
  localparam int unsigned MapAddrW = 19;
  localparam int unsigned VarW     = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK      = 3'd0,
    CMD_CPU_READ  = 3'd1,
    CMD_CPU_WRITE = 3'd2,
    CMD_VID_READ  = 3'd3,
    CMD_VID_WRITE = 3'd4
  } cmd_t;

  typedef enum logic [TgtW-1:0] {
    TGT_NONE = 3'd0,
    TGT_PRG  = 3'd1,
    TGT_WRAM = 3'd2,
    TGT_CHR  = 3'd3,
    TGT_NT   = 3'd4,
    TGT_OPEN = 3'd5,
    TGT_ZERO = 3'd6
  } tgt_t;

  // Board variants
  localparam logic [VarW-1:0] VAR_PLAIN     = 3'd0;
  localparam logic [VarW-1:0] VAR_RAM_GATE  = 3'd1;
  localparam logic [VarW-1:0] VAR_BANK1     = 3'd2;
  localparam logic [VarW-1:0] VAR_BANK2     = 3'd3;
  localparam logic [VarW-1:0] VAR_BANK2_PRG = 3'd4;
  localparam logic [VarW-1:0] VAR_RESET     = VAR_BANK2_PRG;

  // Control register select, address bits 14:13
  localparam logic [1:0] REG_CTRL     = 2'd0;
  localparam logic [1:0] REG_CHR_LOW  = 2'd1;
  localparam logic [1:0] REG_CHR_HIGH = 2'd2;
  localparam logic [1:0] REG_PRG      = 2'd3;

  // Nametable mirroring modes
  localparam logic [1:0] MIR_LOW   = 2'd0;
  localparam logic [1:0] MIR_HIGH  = 2'd1;
  localparam logic [1:0] MIR_VERT  = 2'd2;
  localparam logic [1:0] MIR_HORIZ = 2'd3;

  localparam logic [2:0] SHIFT_LEN  = 3'd5;
  localparam logic [1:0] LOAD_DELAY = 2'd2;

  typedef struct packed {
    logic [1:0] mirror_mode;
    logic       prg_fixed_high;
    logic       prg_small_banks;
    logic       chr_small_banks;
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [3:0] prg_bank_reg;
    logic       ram_off;
  } ctrl_t;

endpackage

>>> rtl/core/slbm_map.sv
// Address decode and bank translation for one bus access.
// Depends on slbm_pkg; purely combinational.
module slbm_map (
  input  slbm_pkg::cmd_t                     cmd,
  input  logic [slbm_pkg::AddrW-1:0]         address,
  input  slbm_pkg::ctrl_t                    ctrl,
  input  logic [slbm_pkg::VarW-1:0]          variant,
  output slbm_pkg::tgt_t                     target,
  output logic [slbm_pkg::MapAddrW-1:0]      mapped_address,
  output logic                               write_enable,
  output logic                               load_write
);

  logic       wram_hit;
  logic       prg_region;
  logic [3:0] prg_bank;
  logic       prg_bit4;
  logic [1:0] wram_bank;
  logic       chr_region;
  logic [4:0] chr_bank;
  logic       nt_bit10;

  assign wram_hit = (address[15:13] == 3'b011);

  // Program ROM bank
  always_comb begin
    prg_region = address[14];
    if (ctrl.prg_small_banks) begin
      if (prg_region != ctrl.prg_fixed_high) begin
        prg_bank = ctrl.prg_bank_reg;
      end else begin
        prg_bank = {4{prg_region}};
      end
    end else begin
      prg_bank = {ctrl.prg_bank_reg[3:1], prg_region};
    end
    prg_bit4 = (variant == slbm_pkg::VAR_BANK2_PRG) && ctrl.chr_bank_low[4];
  end

  // Work RAM bank
  always_comb begin
    if (variant == slbm_pkg::VAR_BANK1) begin
      wram_bank = {1'b0, ctrl.chr_bank_low[3]};
    end else if (variant inside {slbm_pkg::VAR_BANK2, slbm_pkg::VAR_BANK2_PRG}) begin
      wram_bank = ctrl.chr_bank_low[3:2];
    end else begin
      wram_bank = 2'd0;
    end
  end

  // Pattern bank
  always_comb begin
    chr_region = address[12];
    if (ctrl.chr_small_banks) begin
      chr_bank = chr_region ? ctrl.chr_bank_high : ctrl.chr_bank_low;
    end else begin
      chr_bank = {ctrl.chr_bank_low[4:1], chr_region};
    end
  end

  // Nametable mirroring
  always_comb begin
    case (ctrl.mirror_mode)
      slbm_pkg::MIR_LOW:   nt_bit10 = 1'b0;
      slbm_pkg::MIR_HIGH:  nt_bit10 = 1'b1;
      slbm_pkg::MIR_VERT:  nt_bit10 = address[10];
      slbm_pkg::MIR_HORIZ: nt_bit10 = address[11];
      default:             nt_bit10 = 1'b0;
    endcase
  end

  always_comb begin
    target         = slbm_pkg::TGT_NONE;
    mapped_address = '0;
    write_enable   = 1'b0;
    load_write     = 1'b0;
    case (cmd)
      slbm_pkg::CMD_CPU_READ, slbm_pkg::CMD_CPU_WRITE: begin
        if (wram_hit) begin
          if (variant == slbm_pkg::VAR_RAM_GATE && ctrl.chr_bank_low[4]) begin
            target = (cmd == slbm_pkg::CMD_CPU_WRITE) ? slbm_pkg::TGT_NONE
                                                      : slbm_pkg::TGT_OPEN;
          end else if (ctrl.ram_off) begin
            target = (cmd == slbm_pkg::CMD_CPU_WRITE) ? slbm_pkg::TGT_NONE
                                                      : slbm_pkg::TGT_ZERO;
          end else begin
            target         = slbm_pkg::TGT_WRAM;
            mapped_address = {4'd0, wram_bank, address[12:0]};
            write_enable   = (cmd == slbm_pkg::CMD_CPU_WRITE);
          end
        end else if (address[15]) begin
          if (cmd == slbm_pkg::CMD_CPU_WRITE) begin
            load_write = 1'b1;
          end else begin
            target         = slbm_pkg::TGT_PRG;
            mapped_address = {prg_bit4, prg_bank, address[13:0]};
          end
        end else begin
          target = (cmd == slbm_pkg::CMD_CPU_WRITE) ? slbm_pkg::TGT_NONE
                                                    : slbm_pkg::TGT_OPEN;
        end
      end
      slbm_pkg::CMD_VID_READ, slbm_pkg::CMD_VID_WRITE: begin
        if (address[13]) begin
          target         = slbm_pkg::TGT_NT;
          mapped_address = {8'd0, nt_bit10, address[9:0]};
        end else begin
          target         = slbm_pkg::TGT_CHR;
          mapped_address = {2'd0, chr_bank, address[11:0]};
        end
        write_enable = (cmd == slbm_pkg::CMD_VID_WRITE);
      end
      default: begin
        target = slbm_pkg::TGT_NONE;
      end
    endcase
  end

endmodule

>>> rtl/core/serial_loaded_bank_mapper.sv
// Top level of the serial-loaded cartridge bank mapper.
// Depends on slbm_pkg and slbm_map.
//
// Each item on the input stream is one bus event: tuser carries the command
// (tick, CPU read or write, video read or write), tdata the bus address in
// bits 15:0 and the write data byte in bits 23:16. Every item yields exactly
// one result item: tuser carries the target memory, tdata the translated
// address in bits 18:0 and the write strobe in bit 19. The block is a
// two-register pipeline: an item is captured in the input register, decoded
// and translated combinationally while the serial loader and the control
// registers update, and lands in the result register, which drives
// out_tvalid. It takes one item per clock while the output is not stalled.
// The result register stalls the input register only when both are full
// and out_tready is low. CPU writes at 0x8000 and up shift data bit 0 into a
// 5-bit loader, LSB first; the fifth bit commits to the control register
// chosen by address bits 14:13, and data bit 7 resets the loader. After an
// accepted load write, further ones are dropped until two ticks have passed.
// The board variant register (cfg_wdata, written when cfg_wen is high)
// should only be changed while the pipeline is empty.
module serial_loaded_bank_mapper (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // address[15:0], data[23:16]
  input  logic [2:0]  in_tuser,   // cmd[2:0]
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // mapped_address[18:0], write_enable[19], zero pad
  output logic [2:0]  out_tuser,  // target[2:0]
  // Configuration
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_wdata   // board_variant[2:0]
);

  // Pipeline registers
  logic                             s1_valid_r;
  logic [slbm_pkg::CmdW-1:0]        s1_cmd_r;
  logic [slbm_pkg::AddrW-1:0]       s1_addr_r;
  logic [slbm_pkg::DataW-1:0]       s1_data_r;
  logic                             out_valid_r;
  slbm_pkg::tgt_t                   out_target_r;
  logic [slbm_pkg::MapAddrW-1:0]    out_maddr_r;
  logic                             out_we_r;

  // Mapper state
  logic [slbm_pkg::VarW-1:0] variant_r;
  logic [1:0]                delay_r, delay_nxt;
  logic [2:0]                shift_cnt_r, shift_cnt_nxt;
  logic [4:0]                shift_val_r, shift_val_nxt;
  slbm_pkg::ctrl_t           ctrl_r, ctrl_nxt;

  // Decode results
  slbm_pkg::cmd_t                 s1_cmd;
  slbm_pkg::tgt_t                 map_target;
  logic [slbm_pkg::MapAddrW-1:0]  map_addr;
  logic                           map_we;
  logic                           map_load;

  logic       out_free;
  logic       s1_fire;
  logic [4:0] shifted;
  logic [2:0] cnt_inc;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  assign s1_cmd = slbm_pkg::cmd_t'(s1_cmd_r);

  slbm_map u_map (
    .cmd            (s1_cmd),
    .address        (s1_addr_r),
    .ctrl           (ctrl_r),
    .variant        (variant_r),
    .target         (map_target),
    .mapped_address (map_addr),
    .write_enable   (map_we),
    .load_write     (map_load)
  );

  // Serial loader and control register update
  always_comb begin
    delay_nxt     = delay_r;
    shift_cnt_nxt = shift_cnt_r;
    shift_val_nxt = shift_val_r;
    ctrl_nxt      = ctrl_r;
    shifted       = {s1_data_r[0], shift_val_r[4:1]};
    cnt_inc       = shift_cnt_r + 3'd1;
    if (s1_fire) begin
      if (s1_cmd == slbm_pkg::CMD_TICK) begin
        // count down the load delay
        if (delay_r != 2'd0) begin
          delay_nxt = delay_r - 2'd1;
        end
      end else if (map_load && delay_r == 2'd0) begin
        delay_nxt = slbm_pkg::LOAD_DELAY;
        if (s1_data_r[7]) begin
          // loader reset: keep the shift value, force fixed-high small banks
          shift_cnt_nxt            = 3'd0;
          ctrl_nxt.prg_small_banks = 1'b1;
          ctrl_nxt.prg_fixed_high  = 1'b1;
        end else begin
          shift_val_nxt = shifted;
          if (cnt_inc == slbm_pkg::SHIFT_LEN) begin
            // fifth bit: commit to the selected control register
            shift_cnt_nxt = 3'd0;
            case (s1_addr_r[14:13])
              slbm_pkg::REG_CTRL: begin
                ctrl_nxt.mirror_mode     = shifted[1:0];
                ctrl_nxt.prg_fixed_high  = shifted[2];
                ctrl_nxt.prg_small_banks = shifted[3];
                ctrl_nxt.chr_small_banks = shifted[4];
              end
              slbm_pkg::REG_CHR_LOW:  ctrl_nxt.chr_bank_low  = shifted;
              slbm_pkg::REG_CHR_HIGH: ctrl_nxt.chr_bank_high = shifted;
              slbm_pkg::REG_PRG: begin
                ctrl_nxt.prg_bank_reg = shifted[3:0];
                ctrl_nxt.ram_off      = shifted[4];
              end
              default: ctrl_nxt = ctrl_r;
            endcase
          end else begin
            shift_cnt_nxt = cnt_inc;
          end
        end
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r               <= 1'b0;
      out_valid_r              <= 1'b0;
      variant_r                <= slbm_pkg::VAR_RESET;
      delay_r                  <= 2'd0;
      shift_cnt_r              <= 3'd0;
      shift_val_r              <= 5'd0;
      ctrl_r.mirror_mode       <= slbm_pkg::MIR_LOW;
      ctrl_r.prg_fixed_high    <= 1'b1;
      ctrl_r.prg_small_banks   <= 1'b1;
      ctrl_r.chr_small_banks   <= 1'b0;
      ctrl_r.chr_bank_low      <= 5'd0;
      ctrl_r.chr_bank_high     <= 5'd1;
      ctrl_r.prg_bank_reg      <= 4'd0;
      ctrl_r.ram_off           <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (cfg_wen) begin
        variant_r <= cfg_wdata;
      end
      delay_r     <= delay_nxt;
      shift_cnt_r <= shift_cnt_nxt;
      shift_val_r <= shift_val_nxt;
      ctrl_r      <= ctrl_nxt;
    end
  end

  // Payload registers: load on advance
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= in_tuser;
      s1_addr_r <= in_tdata[15:0];
      s1_data_r <= in_tdata[23:16];
    end
    if (s1_fire) begin
      out_target_r <= map_target;
      out_maddr_r  <= map_addr;
      out_we_r     <= map_we;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_target_r;
  assign out_tdata  = {4'd0, out_we_r, out_maddr_r};

endmodule

>>> tb/sv/slbm_access_checker.sv
// Result checker for the serial-loaded bank mapper testbench.
// Mirrors the mapper state from accepted input items and compares every result item.
// Depends on slbm_pkg.
module slbm_access_checker
  import slbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [23:0]       in_tdata,   // address[15:0], data[23:16]
  input  logic [2:0]        in_tuser,   // cmd[2:0]
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [23:0]       out_tdata,  // mapped_address[18:0], write_enable[19], zero pad
  input  logic [2:0]        out_tuser,  // target[2:0]
  input  logic              cfg_wen,
  input  logic [VarW-1:0]   cfg_wdata,  // board_variant[2:0]
  output int unsigned       mismatches,
  output int unsigned       outstanding
);

  typedef struct packed {
    tgt_t                target;
    logic [MapAddrW-1:0] mapped_address;
    logic                write_enable;
  } access_t;

  // CPU address bits 15:13 of the work RAM window
  localparam logic [2:0] WramPage = 3'b011;

  logic [VarW-1:0] variant;
  logic [1:0]      delay_left;
  logic [2:0]      bits_loaded;
  logic [4:0]      shifter;
  ctrl_t           regs;
  access_t         mapped_accesses[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [MapAddrW-1:0] prg_rom_addr(logic [15:0] a);
    logic [3:0] bank;
    logic [4:0] full_bank;
    bank = {regs.prg_bank_reg[3:1], a[14]};
    if (regs.prg_small_banks) begin
      // one 16K half is fixed to the first or last bank, the other switches
      bank = a[14] ? 4'hf : 4'h0;
      if (a[14] != regs.prg_fixed_high) bank = regs.prg_bank_reg;
    end
    full_bank = {1'b0, bank};
    if (variant == VAR_BANK2_PRG) full_bank[4] = regs.chr_bank_low[4];
    return {full_bank, a[13:0]};
  endfunction

  function automatic logic [MapAddrW-1:0] wram_addr(logic [15:0] a);
    logic [1:0] bank;
    bank = 2'b00;
    if (variant == VAR_BANK1) bank = {1'b0, regs.chr_bank_low[3]};
    else if (variant == VAR_BANK2 || variant == VAR_BANK2_PRG) bank = regs.chr_bank_low[3:2];
    return {4'b0, bank, a[12:0]};
  endfunction

  function automatic logic [MapAddrW-1:0] pattern_addr(logic [15:0] a);
    logic [4:0] bank;
    bank = a[12] ? regs.chr_bank_high : regs.chr_bank_low;
    if (!regs.chr_small_banks) bank = {regs.chr_bank_low[4:1], a[12]};
    return {2'b0, bank, a[11:0]};
  endfunction

  function automatic logic [MapAddrW-1:0] nametable_addr(logic [15:0] a);
    logic [10:0] off;
    case (regs.mirror_mode)
      MIR_LOW:  off = {1'b0, a[9:0]};
      MIR_HIGH: off = {1'b1, a[9:0]};
      MIR_VERT: off = {a[10], a[9:0]};
      default:  off = {a[11], a[9:0]};
    endcase
    return {8'b0, off};
  endfunction

  function automatic void shift_in(logic [15:0] a, logic [7:0] d);
    if (delay_left != 0) return;
    delay_left = LOAD_DELAY;
    if (d[7]) begin
      bits_loaded          = 3'd0;
      regs.prg_small_banks = 1'b1;
      regs.prg_fixed_high  = 1'b1;
      return;
    end
    shifter = {d[0], shifter[4:1]};
    bits_loaded++;
    if (bits_loaded != SHIFT_LEN) return;
    bits_loaded = 3'd0;
    case (a[14:13])
      REG_CTRL: begin
        regs.mirror_mode     = shifter[1:0];
        regs.prg_fixed_high  = shifter[2];
        regs.prg_small_banks = shifter[3];
        regs.chr_small_banks = shifter[4];
      end
      REG_CHR_LOW:  regs.chr_bank_low  = shifter;
      REG_CHR_HIGH: regs.chr_bank_high = shifter;
      default: begin
        regs.prg_bank_reg = shifter[3:0];
        regs.ram_off      = shifter[4];
      end
    endcase
  endfunction

  function automatic access_t predict_access(logic [2:0] cmd, logic [15:0] a, logic [7:0] d);
    access_t r;
    logic    wr;
    r.target         = TGT_NONE;
    r.mapped_address = '0;
    r.write_enable   = 1'b0;
    wr = (cmd == CMD_CPU_WRITE);
    case (cmd)
      CMD_TICK: if (delay_left != 0) delay_left--;
      CMD_CPU_READ, CMD_CPU_WRITE: begin
        if (a[15:13] == WramPage) begin
          if (variant == VAR_RAM_GATE && regs.chr_bank_low[4]) begin
            if (!wr) r.target = TGT_OPEN;
          end else if (regs.ram_off) begin
            if (!wr) r.target = TGT_ZERO;
          end else begin
            r.target         = TGT_WRAM;
            r.mapped_address = wram_addr(a);
            r.write_enable   = wr;
          end
        end else if (a[15]) begin
          if (wr) shift_in(a, d);
          else begin
            r.target         = TGT_PRG;
            r.mapped_address = prg_rom_addr(a);
          end
        end else if (!wr) begin
          r.target = TGT_OPEN;
        end
      end
      CMD_VID_READ, CMD_VID_WRITE: begin
        if (a[13]) begin
          r.target         = TGT_NT;
          r.mapped_address = nametable_addr(a);
        end else begin
          r.target         = TGT_CHR;
          r.mapped_address = pattern_addr(a);
        end
        r.write_enable = (cmd == CMD_VID_WRITE);
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    access_t want;
    int      bad;
    bad = 0;
    if (!rst_n) begin
      variant              = VAR_RESET;
      delay_left           = 2'd0;
      bits_loaded          = 3'd0;
      shifter              = 5'd0;
      regs.mirror_mode     = MIR_LOW;
      regs.prg_fixed_high  = 1'b1;
      regs.prg_small_banks = 1'b1;
      regs.chr_small_banks = 1'b0;
      regs.chr_bank_low    = 5'd0;
      regs.chr_bank_high   = 5'd1;
      regs.prg_bank_reg    = 4'd0;
      regs.ram_off         = 1'b0;
      mapped_accesses.delete();
    end else begin
      if (cfg_wen) variant = cfg_wdata;
      if (out_tvalid && out_tready) begin
        if (mapped_accesses.size() == 0) begin
          $error("result item with nothing expected: target %0d, address %0h",
                 out_tuser, out_tdata[18:0]);
          bad++;
        end else begin
          want = mapped_accesses.pop_front();
          if (out_tuser !== want.target) begin
            $error("target: expected %0d, actual %0d", want.target, out_tuser);
            bad++;
          end
          if (out_tdata[18:0] !== want.mapped_address) begin
            $error("mapped_address: expected %0h, actual %0h",
                   want.mapped_address, out_tdata[18:0]);
            bad++;
          end
          if (out_tdata[19] !== want.write_enable) begin
            $error("write_enable: expected %0d, actual %0d", want.write_enable, out_tdata[19]);
            bad++;
          end
        end
      end
      if (in_tvalid && in_tready)
        mapped_accesses.push_back(predict_access(in_tuser, in_tdata[15:0], in_tdata[23:16]));
    end
    mismatches  <= mismatches + bad;
    outstanding <= mapped_accesses.size();
  end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the serial-loaded bank mapper: clock, reset, stimulus and verdict.
// Depends on slbm_pkg, serial_loaded_bank_mapper and slbm_access_checker.
module tb;
  import slbm_pkg::*;

  // Cycles with no item moving on either channel before the run is declared hung
  localparam int unsigned StallLimit = 4000;
  // Random items per board-variant phase
  localparam int unsigned PhaseItems = 155;
  // Command codes the mapper does not define; it must answer them with no target
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  // Variant code past the defined ones; behaves as the plain board
  localparam logic [VarW-1:0] VAR_UNUSED_HI = 3'd7;

  logic            clk;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  logic [23:0]     in_tdata;   // address[15:0], data[23:16]
  logic [2:0]      in_tuser;   // cmd[2:0]
  logic            out_tvalid;
  logic            out_tready;
  logic [23:0]     out_tdata;  // mapped_address[18:0], write_enable[19], zero pad
  logic [2:0]      out_tuser;  // target[2:0]
  logic            cfg_wen;
  logic [VarW-1:0] cfg_wdata;  // board_variant[2:0]

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned stall_cycles = 0;
  int unsigned item_count = 0;
  logic        steady;         // high: neither side idles

  serial_loaded_bank_mapper u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  slbm_access_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Stall the result side at random, about 23 percent of the time, never while steady.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 23);
  end

  // Watchdog: restart the count whenever an item moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one item, with random idle cycles ahead of it, and hold it until accepted.
  // The handshake is sampled right after the edge, so in_tready is the value the
  // block saw at that edge.
  task automatic bus_event(input logic [2:0] cmd, input logic [15:0] addr,
                           input logic [7:0] data);
    while (!steady && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {data, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    item_count++;
  endtask

  // Shift a 5-bit value into a control register, LSB first. A gap of two ticks
  // after each write clears the hold-off; a shorter gap makes the loader drop
  // the next write.
  task automatic load_register(input logic [1:0] sel, input logic [4:0] value,
                               input int unsigned gap);
    for (int i = 0; i < 5; i++) begin
      bus_event(CMD_CPU_WRITE, {1'b1, sel, 13'($urandom)}, {1'b0, 6'($urandom), value[i]});
      repeat (gap) bus_event(CMD_TICK, 16'($urandom), 8'($urandom));
    end
  endtask

  // One CPU or video access aimed at a random region of the bus.
  task automatic random_access();
    logic [15:0] a;
    a = 16'($urandom);
    case ($urandom_range(3))
      0:       a[15] = 1'b1;                         // program ROM / loader
      1:       a[15:13] = 3'b011;                    // work RAM window
      2:       a = 16'($urandom_range(16'h5fff));    // below work RAM
      default: ;
    endcase
    bus_event(3'($urandom_range(CMD_VID_WRITE, CMD_CPU_READ)), a, 8'($urandom));
  endtask

  // Mostly well-formed register loads and accesses, plus loader resets and noise.
  task automatic random_phase(input int unsigned budget);
    int unsigned stop;
    int unsigned pick;
    stop = item_count + budget;
    while (item_count < stop) begin
      pick = $urandom_range(99);
      if (pick < 8)
        load_register(2'($urandom), 5'($urandom),
                      ($urandom_range(9) == 0) ? $urandom_range(1) : 2);
      else if (pick < 13)
        bus_event(CMD_CPU_WRITE, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
      else if (pick < 22)
        bus_event(CMD_TICK, 16'($urandom), 8'($urandom));
      else if (pick < 90)
        random_access();
      else
        bus_event(3'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  // Drain the pipeline, let it settle, then write the board variant.
  task automatic set_variant(input logic [VarW-1:0] v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic run_phase(input logic [VarW-1:0] v, input logic quiet);
    steady <= quiet;
    set_variant(v);
    random_phase(PhaseItems);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_TICK;
    out_tready <= 1'b0;
    cfg_wen   <= 1'b0;
    cfg_wdata <= VAR_RESET;
    steady    <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, at the reset variant: mapping straight out of reset
    bus_event(CMD_CPU_READ,  16'h8000, 8'h00);
    bus_event(CMD_CPU_READ,  16'hffff, 8'hff);
    bus_event(CMD_CPU_READ,  16'h0000, 8'h00);   // open bus
    bus_event(CMD_CPU_WRITE, 16'h5fff, 8'hff);   // no target
    bus_event(CMD_CPU_READ,  16'h6000, 8'h00);
    bus_event(CMD_CPU_WRITE, 16'h7fff, 8'h55);
    bus_event(CMD_VID_READ,  16'h0000, 8'h00);
    bus_event(CMD_VID_WRITE, 16'h1fff, 8'hff);
    bus_event(CMD_VID_READ,  16'hffff, 8'h00);   // bits 15:14 ignored
    bus_event(CMD_VID_WRITE, 16'h2c00, 8'haa);
    bus_event(CMD_UNUSED_LO, 16'h8000, 8'h01);
    bus_event(CMD_UNUSED_HI, 16'hffff, 8'hff);
    // Loader reset, then a load write inside the hold-off, which must be dropped
    bus_event(CMD_CPU_WRITE, 16'h8000, 8'h80);
    bus_event(CMD_CPU_WRITE, 16'he000, 8'h01);
    bus_event(CMD_TICK, 16'h0000, 8'h00);
    bus_event(CMD_TICK, 16'hffff, 8'hff);
    // Program register all ones: work RAM switched off, reads come back zero
    load_register(REG_PRG, 5'h1f, 2);
    bus_event(CMD_CPU_READ,  16'h6123, 8'h00);
    bus_event(CMD_CPU_WRITE, 16'h7000, 8'h00);

    // Random part, one phase per variant; one phase runs with no idling at all
    run_phase(VAR_PLAIN,     1'b0);
    run_phase(VAR_RAM_GATE,  1'b0);
    run_phase(VAR_BANK1,     1'b0);
    run_phase(VAR_BANK2,     1'b1);
    run_phase(VAR_BANK2_PRG, 1'b0);
    run_phase(VAR_UNUSED_HI, 1'b0);

    // Drain, then give the pipeline time to show any stray result
    in_tvalid <= 1'b0;
    steady    <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/slbm_pkg.sv
rtl/core/slbm_map.sv
rtl/core/serial_loaded_bank_mapper.sv
tb/sv/slbm_access_checker.sv
tb/sv/tb.sv
